// ----- rtl/wiqp_pkg.sv -----
// Shared types, codes and constants of the WAVE IQ header parser.
package wiqp_pkg;

  localparam int MAX_CHUNKS = 256;
  localparam int CHUNK_W    = $clog2(MAX_CHUNKS + 1);
  localparam int POS_W      = 41;
  localparam int FS_W       = 40;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [POS_W-1:0] HDR_START  = POS_W'(12);
  localparam logic [POS_W-1:0] BODY_START = POS_W'(20);
  localparam logic [FS_W-1:0]  RIFF_MIN   = FS_W'(12);
  localparam logic [31:0]      FMT_MIN    = 32'd16;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;
  localparam logic [15:0] CH_IQ     = 16'd2;
  localparam logic [15:0] BITS_PCM  = 16'd16;
  localparam logic [15:0] BITS_FLT  = 16'd32;
  localparam logic [3:0]  FB_PCM    = 4'd4;
  localparam logic [3:0]  FB_FLT    = 4'd8;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_WAIT,
    PH_HDR,
    PH_FMT,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK,
    ST_NOT_RIFF,
    ST_FMT_SMALL,
    ST_FMT_PAST_END,
    ST_GAVE_UP,
    ST_NO_FMT,
    ST_BAD_TAG,
    ST_BAD_CHANNELS,
    ST_PCM_BITS,
    ST_FLOAT_BITS,
    ST_ZERO_RATE,
    ST_NO_DATA,
    ST_TRUNCATED,
    ST_NO_FRAMES
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic        is_float;
    logic [31:0] sample_rate;
    logic [39:0] data_offset;
    logic [29:0] frame_count;
    logic [3:0]  frame_bytes;
  } result_t;

endpackage

// ----- rtl/wiqp_in_stage.sv -----
// Input register: holds one byte word until the parser takes it.
module wiqp_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wiqp_pkg::in_word_t in_word,
  input  logic              advance,
  output logic              word_valid,
  output wiqp_pkg::in_word_t word
);

  assign in_ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_word;
    end
  end

endmodule

// ----- rtl/wiqp_parser.sv -----
// Chunk walker: parse state, per-byte update and verdict logic.
module wiqp_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [wiqp_pkg::FS_W-1:0] cfg_wdata,
  input  logic                   step,
  input  wiqp_pkg::in_word_t     word,
  output logic                   res_valid,
  output wiqp_pkg::result_t      res
);

  localparam int PW = wiqp_pkg::POS_W;
  localparam int CW = wiqp_pkg::CHUNK_W;

  logic [wiqp_pkg::FS_W-1:0] file_size;
  logic [PW-1:0] position, position_next, cur_pos;
  logic [PW-1:0] hdr_at, hdr_at_next, cur_hdr;
  logic [PW-1:0] body_at, body_at_next, cur_body;
  wiqp_pkg::phase_t phase, phase_next, cur_phase;
  logic [31:0] tag_shift, tag_shift_next, cur_tag;
  logic [31:0] size_shift, size_shift_next, cur_size;
  logic        riff_bad, riff_bad_next, cur_riff_bad;
  logic [15:0] fmt_tag, fmt_tag_next, cur_fmt_tag;
  logic        ch_ok, ch_ok_next, cur_ch_ok;
  logic        bits16, bits16_next, cur_bits16;
  logic        bits32, bits32_next, cur_bits32;
  logic [31:0] rate, rate_next, cur_rate;
  logic [39:0] data_start, data_start_next, cur_dstart;
  logic [31:0] data_length, data_length_next, cur_dlen;
  logic [PW-1:0] data_end, data_end_next, cur_dend;
  logic [CW-1:0] chunks, chunks_next, cur_chunks;
  logic        fmt_found, fmt_found_next, cur_fmt_found;
  logic        data_found, data_found_next, cur_data_found;
  logic [3:0]  sub_off, sub_off_next, cur_off;

  logic [7:0]    b;
  logic [2:0]    k;
  logic [31:0]   ac_size;
  logic [PW-1:0] ac_hdr, ac_body, dend_now, fs_ext;
  logic          ac_over, fmt_over;
  logic [CW-1:0] chunks_inc;
  logic          ac_go, lc_go, lc_over, do_fail, do_verdict, emit;
  wiqp_pkg::status_t fail_code;
  logic [15:0]   w16;

  function automatic wiqp_pkg::result_t make_verdict(
    input logic        fmt_f,
    input logic [15:0] tag,
    input logic        chk,
    input logic        b16,
    input logic        b32,
    input logic [31:0] rt,
    input logic        data_f,
    input logic [PW-1:0] dend,
    input logic [PW-1:0] fs,
    input logic [39:0] dstart,
    input logic [31:0] dlen
  );
    wiqp_pkg::result_t r;
    logic              flt;
    logic [29:0]       frames;
    r      = '0;
    flt    = (tag == wiqp_pkg::FMT_FLOAT);
    frames = flt ? {1'b0, dlen[31:3]} : dlen[31:2];
    if (!fmt_f) begin
      r.status = wiqp_pkg::ST_NO_FMT;
    end else if (tag != wiqp_pkg::FMT_PCM && tag != wiqp_pkg::FMT_FLOAT) begin
      r.status = wiqp_pkg::ST_BAD_TAG;
    end else if (!chk) begin
      r.status = wiqp_pkg::ST_BAD_CHANNELS;
    end else if (!flt && !b16) begin
      r.status = wiqp_pkg::ST_PCM_BITS;
    end else if (flt && !b32) begin
      r.status = wiqp_pkg::ST_FLOAT_BITS;
    end else if (rt == 32'd0) begin
      r.status = wiqp_pkg::ST_ZERO_RATE;
    end else if (!data_f) begin
      r.status = wiqp_pkg::ST_NO_DATA;
    end else if (dend > fs) begin
      r.status = wiqp_pkg::ST_TRUNCATED;
    end else if (frames == 30'd0) begin
      r.status = wiqp_pkg::ST_NO_FRAMES;
    end else begin
      r.status      = wiqp_pkg::ST_OK;
      r.is_float    = flt;
      r.sample_rate = rt;
      r.data_offset = dstart;
      r.frame_count = frames;
      r.frame_bytes = flt ? wiqp_pkg::FB_FLT : wiqp_pkg::FB_PCM;
    end
    return r;
  endfunction

  // Effective state: a first byte restarts the parse before it is used.
  always_comb begin
    if (word.first) begin
      cur_pos        = '0;
      cur_hdr        = wiqp_pkg::HDR_START;
      cur_body       = wiqp_pkg::BODY_START;
      cur_phase      = wiqp_pkg::PH_RIFF;
      cur_tag        = '0;
      cur_size       = '0;
      cur_riff_bad   = 1'b0;
      cur_fmt_tag    = '0;
      cur_ch_ok      = 1'b0;
      cur_bits16     = 1'b0;
      cur_bits32     = 1'b0;
      cur_rate       = '0;
      cur_dstart     = '0;
      cur_dlen       = '0;
      cur_dend       = '0;
      cur_chunks     = '0;
      cur_fmt_found  = 1'b0;
      cur_data_found = 1'b0;
      cur_off        = '0;
    end else begin
      cur_pos        = position;
      cur_hdr        = hdr_at;
      cur_body       = body_at;
      cur_phase      = phase;
      cur_tag        = tag_shift;
      cur_size       = size_shift;
      cur_riff_bad   = riff_bad;
      cur_fmt_tag    = fmt_tag;
      cur_ch_ok      = ch_ok;
      cur_bits16     = bits16;
      cur_bits32     = bits32;
      cur_rate       = rate;
      cur_dstart     = data_start;
      cur_dlen       = data_length;
      cur_dend       = data_end;
      cur_chunks     = chunks;
      cur_fmt_found  = fmt_found;
      cur_data_found = data_found;
      cur_off        = sub_off;
    end
  end

  assign b          = word.data_byte;
  assign fs_ext     = {1'b0, file_size};
  assign ac_size    = (cur_phase == wiqp_pkg::PH_FMT) ? cur_size : {b, cur_size[23:0]};
  assign ac_hdr     = cur_body + PW'(ac_size) + PW'(ac_size[0]);
  assign ac_body    = cur_body + PW'(ac_size) + PW'({3'b100, ac_size[0]});
  assign dend_now   = cur_body + PW'(ac_size);
  assign ac_over    = ac_body > fs_ext;
  assign fmt_over   = (cur_body + PW'(wiqp_pkg::FMT_MIN)) > fs_ext;
  assign chunks_inc = cur_chunks + CW'(1);
  assign k          = (cur_phase == wiqp_pkg::PH_WAIT) ? 3'd0 : cur_off[2:0];
  assign w16        = {b, cur_tag[7:0]};

  always_comb begin
    position_next    = cur_pos;
    hdr_at_next      = cur_hdr;
    body_at_next     = cur_body;
    phase_next       = cur_phase;
    tag_shift_next   = cur_tag;
    size_shift_next  = cur_size;
    riff_bad_next    = cur_riff_bad;
    fmt_tag_next     = cur_fmt_tag;
    ch_ok_next       = cur_ch_ok;
    bits16_next      = cur_bits16;
    bits32_next      = cur_bits32;
    rate_next        = cur_rate;
    data_start_next  = cur_dstart;
    data_length_next = cur_dlen;
    data_end_next    = cur_dend;
    chunks_next      = cur_chunks;
    fmt_found_next   = cur_fmt_found;
    data_found_next  = cur_data_found;
    sub_off_next     = cur_off;
    ac_go            = 1'b0;
    lc_go            = 1'b0;
    lc_over          = 1'b0;
    do_fail          = 1'b0;
    do_verdict       = 1'b0;
    fail_code        = wiqp_pkg::ST_OK;
    emit             = 1'b0;
    res              = '0;

    if (cur_phase != wiqp_pkg::PH_DONE) begin
      if (cur_pos != '1) begin
        position_next = cur_pos + PW'(1);
      end
      unique case (cur_phase)
        wiqp_pkg::PH_RIFF: begin
          if (cur_pos == '0 && file_size < wiqp_pkg::RIFF_MIN) begin
            do_fail   = 1'b1;
            fail_code = wiqp_pkg::ST_NOT_RIFF;
          end else begin
            tag_shift_next = {cur_tag[23:0], b};
            if (cur_pos[3:0] == 4'd3 && tag_shift_next != wiqp_pkg::TAG_RIFF) begin
              riff_bad_next = 1'b1;
            end
            if (cur_pos[3:0] == 4'd11) begin
              if (cur_riff_bad || tag_shift_next != wiqp_pkg::TAG_WAVE) begin
                do_fail   = 1'b1;
                fail_code = wiqp_pkg::ST_NOT_RIFF;
              end else begin
                size_shift_next = '0;
                lc_go           = 1'b1;
                lc_over         = cur_body > fs_ext;
              end
            end
          end
        end
        wiqp_pkg::PH_WAIT, wiqp_pkg::PH_HDR: begin
          if (cur_phase == wiqp_pkg::PH_HDR || cur_pos == cur_hdr) begin
            phase_next   = wiqp_pkg::PH_HDR;
            sub_off_next = {1'b0, k} + 4'd1;
            case (k)
              3'd0:    tag_shift_next = {24'd0, b};
              3'd1,
              3'd2,
              3'd3:    tag_shift_next = {cur_tag[23:0], b};
              3'd4:    size_shift_next = {24'd0, b};
              3'd5:    size_shift_next[15:8] = b;
              3'd6:    size_shift_next[23:16] = b;
              default: size_shift_next[31:24] = b;
            endcase
            if (k == 3'd7) begin
              if (cur_tag == wiqp_pkg::TAG_FMT && !cur_fmt_found) begin
                if (ac_size < wiqp_pkg::FMT_MIN) begin
                  do_fail   = 1'b1;
                  fail_code = wiqp_pkg::ST_FMT_SMALL;
                end else if (fmt_over) begin
                  do_fail   = 1'b1;
                  fail_code = wiqp_pkg::ST_FMT_PAST_END;
                end else begin
                  fmt_tag_next = '0;
                  ch_ok_next   = 1'b0;
                  bits16_next  = 1'b0;
                  bits32_next  = 1'b0;
                  rate_next    = '0;
                  phase_next   = wiqp_pkg::PH_FMT;
                  sub_off_next = '0;
                end
              end else begin
                if (cur_tag == wiqp_pkg::TAG_DATA && !cur_data_found) begin
                  data_start_next  = cur_body[39:0];
                  data_length_next = ac_size;
                  data_end_next    = dend_now;
                  data_found_next  = 1'b1;
                end
                ac_go = 1'b1;
              end
            end
          end
        end
        wiqp_pkg::PH_FMT: begin
          sub_off_next = cur_off + 4'd1;
          case (cur_off)
            4'd0:    fmt_tag_next[7:0] = b;
            4'd1:    fmt_tag_next[15:8] = b;
            4'd2:    tag_shift_next = {24'd0, b};
            4'd3:    ch_ok_next = (w16 == wiqp_pkg::CH_IQ);
            4'd4:    rate_next[7:0] = b;
            4'd5:    rate_next[15:8] = b;
            4'd6:    rate_next[23:16] = b;
            4'd7:    rate_next[31:24] = b;
            4'd14:   tag_shift_next = {24'd0, b};
            4'd15: begin
              bits16_next    = (w16 == wiqp_pkg::BITS_PCM);
              bits32_next    = (w16 == wiqp_pkg::BITS_FLT);
              fmt_found_next = 1'b1;
              ac_go          = 1'b1;
            end
            default: ;
          endcase
        end
        wiqp_pkg::PH_DONE: ;
        default: ;
      endcase
    end

    // Chunk closed: move to the next header, stop once both chunks are known.
    if (ac_go) begin
      hdr_at_next  = ac_hdr;
      body_at_next = ac_body;
      if (fmt_found_next && data_found_next) begin
        do_verdict = 1'b1;
      end else begin
        chunks_next = chunks_inc;
        lc_go       = 1'b1;
        lc_over     = ac_over;
      end
    end

    if (lc_go) begin
      if (chunks_next >= CW'(wiqp_pkg::MAX_CHUNKS)) begin
        do_fail   = 1'b1;
        fail_code = wiqp_pkg::ST_GAVE_UP;
      end else if (lc_over) begin
        do_verdict = 1'b1;
      end else begin
        phase_next = wiqp_pkg::PH_WAIT;
      end
    end

    if (do_fail) begin
      res.status = fail_code;
      emit       = 1'b1;
      phase_next = wiqp_pkg::PH_DONE;
    end else if (do_verdict) begin
      res = make_verdict(fmt_found_next, fmt_tag_next, ch_ok_next, bits16_next,
                         bits32_next, rate_next, data_found_next, data_end_next,
                         fs_ext, data_start_next, data_length_next);
      emit       = 1'b1;
      phase_next = wiqp_pkg::PH_DONE;
    end
  end

  assign res_valid = step && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wiqp_pkg::PH_RIFF;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size   <= '0;
      position    <= '0;
      hdr_at      <= wiqp_pkg::HDR_START;
      body_at     <= wiqp_pkg::BODY_START;
      tag_shift   <= '0;
      size_shift  <= '0;
      riff_bad    <= 1'b0;
      fmt_tag     <= '0;
      ch_ok       <= 1'b0;
      bits16      <= 1'b0;
      bits32      <= 1'b0;
      rate        <= '0;
      data_start  <= '0;
      data_length <= '0;
      data_end    <= '0;
      chunks      <= '0;
      fmt_found   <= 1'b0;
      data_found  <= 1'b0;
      sub_off     <= '0;
    end else begin
      if (cfg_we) begin
        file_size <= cfg_wdata;
      end
      if (step) begin
        position    <= position_next;
        hdr_at      <= hdr_at_next;
        body_at     <= body_at_next;
        tag_shift   <= tag_shift_next;
        size_shift  <= size_shift_next;
        riff_bad    <= riff_bad_next;
        fmt_tag     <= fmt_tag_next;
        ch_ok       <= ch_ok_next;
        bits16      <= bits16_next;
        bits32      <= bits32_next;
        rate        <= rate_next;
        data_start  <= data_start_next;
        data_length <= data_length_next;
        data_end    <= data_end_next;
        chunks      <= chunks_next;
        fmt_found   <= fmt_found_next;
        data_found  <= data_found_next;
        sub_off     <= sub_off_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_one_verdict: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (phase != wiqp_pkg::PH_DONE || word.first))
    else $error("verdict given twice for one file");

  a_done_after_verdict: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> phase == wiqp_pkg::PH_DONE)
    else $error("parser kept walking after its verdict");

  a_ok_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == wiqp_pkg::ST_OK |->
      (res.frame_bytes == wiqp_pkg::FB_PCM && !res.is_float) ||
      (res.frame_bytes == wiqp_pkg::FB_FLT && res.is_float))
    else $error("frame size disagrees with sample format");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != wiqp_pkg::ST_OK |->
      res.frame_bytes == 4'd0 && res.frame_count == 30'd0 && res.sample_rate == 32'd0 &&
      res.data_offset == 40'd0 && !res.is_float)
    else $error("error verdict carries payload");
`endif

endmodule

// ----- rtl/wiqp_out_stage.sv -----
// Result register: holds one verdict word until the receiver takes it.
module wiqp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wiqp_pkg::result_t res_in,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output wiqp_pkg::result_t res_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- rtl/wave_iq_header_parser_core.sv -----
// Top level of the streaming RIFF/WAVE header parser for IQ captures.
//
// Input channel (in_valid/in_ready): one file byte per word, data_byte plus
// first, which marks byte zero of a new file and restarts the parse.
// Output channel (out_valid/out_ready): one verdict word per file: status,
// is_float, sample_rate, data_offset, frame_count and frame_bytes; on an
// error status every other field is zero.
// Config: write file_size with cfg_we/cfg_wdata only while the block is idle; the block does not enforce this.
// Throughput: one byte per cycle unless an untaken verdict stalls it. Each
// byte passes the input register, the combinational chunk-walk logic
// (header match, size adds, end-of-file compare) and, when it settles the
// verdict, the result register, which drives the output channel.
// Bytes after the verdict are swallowed until the next first word.
// Stall: while the result register holds an untaken verdict, hold the
// parser; the input register then fills and in_ready drops.
// Reset (rst, synchronous): clear file_size, drop any held words and return
// the parser to the RIFF tag check; no clearing pass is needed.
module wave_iq_header_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [39:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic        is_float,
  output logic [31:0] sample_rate,
  output logic [39:0] data_offset,
  output logic [29:0] frame_count,
  output logic [3:0]  frame_bytes
);

  wiqp_pkg::in_word_t in_word;
  wiqp_pkg::in_word_t word;
  wiqp_pkg::result_t  res;
  wiqp_pkg::result_t  res_out;
  logic               word_valid;
  logic               advance;
  logic               can_load;
  logic               res_valid;

  assign in_word.data_byte = data_byte;
  assign in_word.first     = first;

  // Advance a byte only when a verdict it might raise has a place to land.
  assign advance = word_valid && can_load;

  wiqp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  wiqp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  wiqp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign status      = res_out.status;
  assign is_float    = res_out.is_float;
  assign sample_rate = res_out.sample_rate;
  assign data_offset = res_out.data_offset;
  assign frame_count = res_out.frame_count;
  assign frame_bytes = res_out.frame_bytes;

endmodule
